// ===== rtl/ncpd_pkg.sv =====
// ncpd_pkg: shared types, constants and tables for the composite pixel decoder.
// No dependencies; imported by every module in rtl/.
package ncpd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int WINDOW_DEPTH = 12;
  localparam int PHASE_W      = 4;
  localparam int MAX_SAMPLES  = 16;
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_RESULTS  = 8;
  localparam int LUMA_W       = 20;
  localparam int CHROMA_W     = 24;
  localparam int CARRY_W      = 13;
  localparam int COLUMN_W     = 12;
  localparam int COL_OUT_W    = 11;
  localparam int SPP_W        = 5;
  localparam int OW_W         = 12;
  localparam int REM_W        = 5;
  localparam int RES_CNT_W    = 4;
  localparam int FQ_DEPTH     = 2;
  localparam int FQ_PTR_W     = 1;
  localparam int FQ_CNT_W     = 2;
  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_W    = 3;
  localparam int OUT_CNT_W    = 4;
  localparam int OCC_W        = 5;
  localparam int ACC_W        = 42;
  localparam int T_W          = 10;

  localparam logic signed [16:0] K_R_V   = 17'sd9338;
  localparam logic signed [16:0] K_G_U   = 17'sd3233;
  localparam logic signed [16:0] K_G_V   = 17'sd4756;
  localparam logic signed [16:0] K_B_U   = 17'sd16647;
  localparam logic [T_W-1:0]     RECIP3  = 10'd683;

  localparam logic signed [SAMPLE_W-1:0] LEVEL_TAB [16] = '{
    -16'sd873,  16'sd0,    16'sd2495, 16'sd5905,
    16'sd3160,  16'sd5489, 16'sd8192, 16'sd8192,
    -16'sd1248, -16'sd582, 16'sd1414, 16'sd4158,
    16'sd1954,  16'sd3784, 16'sd6071, 16'sd6071
  };

  localparam logic signed [SAMPLE_W-1:0] SIN_TAB [WINDOW_DEPTH] = '{
    16'sd15826,  16'sd15826,  16'sd11585,  16'sd4240,  -16'sd4240, -16'sd11585,
    -16'sd15826, -16'sd15826, -16'sd11585, -16'sd4240, 16'sd4240,  16'sd11585
  };

  localparam logic signed [SAMPLE_W-1:0] COS_TAB [WINDOW_DEPTH] = '{
    16'sd4240,   -16'sd4240,  -16'sd11585, -16'sd15826, -16'sd15826, -16'sd11585,
    -16'sd4240,  16'sd4240,   16'sd11585,  16'sd15826,  16'sd15826,  16'sd11585
  };

  typedef enum logic [1:0] {
    REG_START_PHASE = 2'd0,
    REG_SPP         = 2'd1,
    REG_SATURATION  = 2'd2,
    REG_OUT_WIDTH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]      start_phase;
    logic [SPP_W-1:0] samples_per_pixel;
    logic            saturation_on;
    logic [OW_W-1:0] out_width;
  } cfg_t;

  typedef struct packed {
    logic [8:0] pixel_index;
    logic       line_start;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [COL_OUT_W-1:0] column;
    logic                 last_in_run;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_FRAME = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         hue;
    logic [1:0]         level;
    logic [2:0]         emph;
    logic [PHASE_W-1:0] phase0;
  } job_t;

  typedef enum logic {
    TOK_PIXEL  = 1'b0,
    TOK_FINISH = 1'b1
  } tok_kind_t;

  typedef struct packed {
    logic                 valid;
    tok_kind_t            kind;
    logic [COL_OUT_W-1:0] col;
  } tok_t;

  typedef struct packed {
    logic signed [LUMA_W-1:0]   luma;
    logic signed [CHROMA_W-1:0] u;
    logic signed [CHROMA_W-1:0] v;
  } sums_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  function automatic logic in_phase(input logic [3:0] c, input logic [PHASE_W-1:0] p);
    logic [4:0] total;
    logic [4:0] m;
    total = {1'b0, c} + {1'b0, p};
    if (total >= 5'd24) begin
      m = total - 5'd24;
    end else if (total >= 5'd12) begin
      m = total - 5'd12;
    end else begin
      m = total;
    end
    return m < 5'd6;
  endfunction

  function automatic logic [PHASE_W-1:0] phase_prev(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] r;
    if (p == '0 || p > PHASE_W'(WINDOW_DEPTH - 1)) begin
      r = PHASE_W'(WINDOW_DEPTH - 1);
    end else begin
      r = p - PHASE_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/ncpd_front.sv =====
// ncpd_front: accepts palette pixels, decodes hue/level/emphasis and line ops,
// and holds them in a short job queue. Depends on ncpd_pkg.
module ncpd_front import ncpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   item,
  input  logic [3:0] start_phase,
  output job_t       job,
  output logic       job_valid,
  input  logic       job_take
);

  job_t                q_mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] cnt;
  job_t                dec;
  logic                push_ok;
  logic                take_ok;
  logic [3:0]          hue;

  assign full      = (cnt == FQ_CNT_W'(FQ_DEPTH));
  assign job_valid = (cnt != '0);
  assign job       = q_mem[rd_ptr];
  assign push_ok   = push && !full;
  assign take_ok   = job_take && job_valid;
  assign hue       = item.pixel_index[3:0];

  always_comb begin
    dec.hue = hue;
    if (hue > 4'd13) begin
      dec.level = 2'd1;
      dec.emph  = 3'd0;
    end else begin
      dec.level = item.pixel_index[5:4];
      dec.emph  = item.pixel_index[8:6];
    end
    if (item.frame_start) begin
      dec.op = OP_FRAME;
    end else if (item.line_start) begin
      dec.op = OP_LINE;
    end else begin
      dec.op = OP_NONE;
    end
    if (start_phase >= 4'd12) begin
      dec.phase0 = start_phase - 4'd12;
    end else begin
      dec.phase0 = start_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + FQ_PTR_W'(1);
      end
      if (take_ok) begin
        rd_ptr <= rd_ptr + FQ_PTR_W'(1);
      end
      unique case ({push_ok, take_ok})
        2'b10:   cnt <= cnt + FQ_CNT_W'(1);
        2'b01:   cnt <= cnt - FQ_CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/ncpd_sampler.sv =====
// ncpd_sampler: per-pixel sequencer, composite sample generation, 12-deep window,
// running Y/U/V sums and horizontal scaling carry. Depends on ncpd_pkg.
module ncpd_sampler import ncpd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  job_t  job,
  input  logic  job_valid,
  output logic  job_take,
  input  logic  room,
  output tok_t  tok,
  output sums_t sums
);

  seq_state_t             state, state_next;
  logic [REM_W-1:0]       rem, rem_next;
  logic [RES_CNT_W-1:0]   count, count_next;
  logic                   stepped, stepped_next;
  logic [PHASE_W-1:0]     phase, phase_next;
  logic [CARRY_W-1:0]     carry, carry_next;
  logic [COLUMN_W-1:0]    column, column_next;
  logic [3:0]             hue, hue_next;
  logic [1:0]             level, level_next;
  logic [2:0]             emph, emph_next;
  tok_t                   tok_next;

  logic signed [SAMPLE_W-1:0] window [WINDOW_DEPTH];
  logic signed [LUMA_W-1:0]   sum_luma;
  logic signed [CHROMA_W-1:0] sum_u;
  logic signed [CHROMA_W-1:0] sum_v;

  logic                       s1_valid;
  logic                       s1_sat;
  logic signed [31:0]         s1_su, s1_ou, s1_sv, s1_ov;
  logic signed [SAMPLE_W:0]   s1_dl;

  logic                       load;
  logic                       do_sample;
  logic                       do_clear;
  logic [SPP_W-1:0]           spp_eff;
  logic [OW_W-1:0]            ow_eff;
  logic [CARRY_W-1:0]         thr;
  logic [PHASE_W-1:0]         p_new;
  logic                       att;
  logic [3:0]                 base;
  logic signed [SAMPLE_W-1:0] lo, hi, smp, old, k_sin, k_cos;
  logic signed [19:0]         du, dv;

  function automatic logic signed [18:0] round13(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + 32'sd4096;
    return t[31:13];
  endfunction

  assign sums = '{luma: sum_luma, u: sum_u, v: sum_v};

  always_comb begin
    if (cfg.samples_per_pixel == '0) begin
      spp_eff = SPP_W'(1);
    end else if (cfg.samples_per_pixel > SPP_W'(MAX_SAMPLES)) begin
      spp_eff = SPP_W'(MAX_SAMPLES);
    end else begin
      spp_eff = cfg.samples_per_pixel;
    end
    if (cfg.out_width > OW_W'(MAX_WIDTH)) begin
      ow_eff = OW_W'(MAX_WIDTH);
    end else begin
      ow_eff = cfg.out_width;
    end
    thr = {spp_eff, 8'd0};
  end

  always_comb begin
    p_new = phase_prev(phase);
    att   = (emph[0] && in_phase(4'd12, p_new)) ||
            (emph[1] && in_phase(4'd4, p_new)) ||
            (emph[2] && in_phase(4'd8, p_new));
    base  = {att, 1'b0, level};
    lo    = LEVEL_TAB[base];
    hi    = LEVEL_TAB[base + 4'd4];
    if (hue == 4'd0) begin
      lo = hi;
    end
    if (hue > 4'd12) begin
      hi = lo;
    end
    smp   = in_phase(hue, p_new) ? hi : lo;
    old   = window[p_new];
    k_sin = SIN_TAB[p_new];
    k_cos = COS_TAB[p_new];
  end

  always_comb begin
    state_next   = state;
    rem_next     = rem;
    count_next   = count;
    stepped_next = stepped;
    phase_next   = phase;
    carry_next   = carry;
    column_next  = column;
    hue_next     = hue;
    level_next   = level;
    emph_next    = emph;
    tok_next     = '0;
    job_take     = 1'b0;
    do_sample    = 1'b0;
    do_clear     = 1'b0;
    load         = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        load = job_valid;
      end
      SEQ_RUN: begin
        if (stepped && carry >= thr) begin
          if (count == RES_CNT_W'(MAX_RESULTS)) begin
            carry_next = carry - thr;
          end else if (room) begin
            carry_next    = carry - thr;
            column_next   = column + COLUMN_W'(1);
            count_next    = count + RES_CNT_W'(1);
            tok_next.valid = 1'b1;
            tok_next.kind  = TOK_PIXEL;
            tok_next.col   = column[COL_OUT_W-1:0];
          end
        end else if (rem != '0) begin
          do_sample    = 1'b1;
          phase_next   = p_new;
          carry_next   = carry + CARRY_W'(ow_eff);
          rem_next     = rem - REM_W'(1);
          stepped_next = 1'b1;
        end else begin
          tok_next.valid = 1'b1;
          tok_next.kind  = TOK_FINISH;
          if (job_valid) begin
            load = 1'b1;
          end else begin
            state_next = SEQ_IDLE;
          end
        end
      end
    endcase
    if (load) begin
      job_take     = 1'b1;
      state_next   = SEQ_RUN;
      hue_next     = job.hue;
      level_next   = job.level;
      emph_next    = job.emph;
      rem_next     = REM_W'(spp_eff);
      count_next   = '0;
      stepped_next = 1'b0;
      if (job.op != OP_NONE) begin
        do_clear    = 1'b1;
        carry_next  = '0;
        column_next = '0;
      end
      if (job.op == OP_FRAME) begin
        phase_next = job.phase0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SEQ_IDLE;
      rem     <= '0;
      count   <= '0;
      stepped <= 1'b0;
      phase   <= '0;
      carry   <= '0;
      column  <= '0;
      tok     <= '0;
    end else begin
      state   <= state_next;
      rem     <= rem_next;
      count   <= count_next;
      stepped <= stepped_next;
      phase   <= phase_next;
      carry   <= carry_next;
      column  <= column_next;
      tok     <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    hue   <= hue_next;
    level <= level_next;
    emph  <= emph_next;
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
    end else if (do_sample) begin
      window[p_new] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= do_sample;
    end
  end

  always_ff @(posedge clk) begin
    s1_sat <= cfg.saturation_on;
    s1_su  <= smp * k_sin;
    s1_ou  <= old * k_sin;
    s1_sv  <= smp * k_cos;
    s1_ov  <= old * k_cos;
    s1_dl  <= (SAMPLE_W+1)'(smp) - (SAMPLE_W+1)'(old);
  end

  always_comb begin
    du = 20'(round13(s1_su)) - 20'(round13(s1_ou));
    dv = 20'(round13(s1_sv)) - 20'(round13(s1_ov));
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      sum_luma <= '0;
      sum_u    <= '0;
      sum_v    <= '0;
    end else if (s1_valid) begin
      sum_luma <= sum_luma + LUMA_W'(s1_dl);
      if (s1_sat) begin
        sum_u <= sum_u + CHROMA_W'(du);
        sum_v <= sum_v + CHROMA_W'(dv);
      end
    end
  end

endmodule

// ===== rtl/ncpd_rgb.sv =====
// ncpd_rgb: holds the newest result to mark the last of each run, converts YUV
// sums to clamped RGB in a short pipeline, and queues results. Depends on ncpd_pkg.
module ncpd_rgb import ncpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tok_t      tok,
  input  sums_t     sums,
  output logic      room,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  typedef struct packed {
    logic           zero;
    logic           sat;
    logic [T_W-1:0] t;
  } chan_t;

  logic                       pend_valid;
  sums_t                      pend;
  logic [COL_OUT_W-1:0]       pend_col;

  logic                       s1_valid;
  logic                       s1_last;
  logic [COL_OUT_W-1:0]       s1_col;
  logic signed [ACC_W-1:0]    s1_y, s1_rv, s1_gu, s1_gv, s1_bu;

  logic                       s2_valid;
  logic                       s2_last;
  logic [COL_OUT_W-1:0]       s2_col;
  logic signed [ACC_W-1:0]    s2_r, s2_g, s2_b;

  logic                       s3_valid;
  logic                       s3_last;
  logic [COL_OUT_W-1:0]       s3_col;
  chan_t                      s3_r, s3_g, s3_b;

  out_item_t                  q_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]       wr_ptr;
  logic [OUT_PTR_W-1:0]       rd_ptr;
  logic [OUT_CNT_W-1:0]       cnt;

  logic                       launch;
  logic                       launch_last;
  logic                       tok_pix;
  logic                       pop_ok;
  logic [OCC_W-1:0]           occ;
  out_item_t                  conv;

  function automatic chan_t classify(input logic signed [ACC_W-1:0] acc);
    chan_t      c;
    logic [37:0] x;
    c.zero = acc[ACC_W-1] || (acc == '0);
    c.sat  = !acc[ACC_W-1] && (acc[ACC_W-2:30] != '0);
    x      = {acc[29:0], 8'd0} - {8'd0, acc[29:0]};
    c.t    = x[37:28];
    return c;
  endfunction

  function automatic logic [7:0] to_byte(input chan_t c);
    logic [19:0] q;
    logic [7:0]  b;
    q = 20'(c.t) * 20'(RECIP3);
    if (c.zero) begin
      b = 8'd0;
    end else if (c.sat || q[19]) begin
      b = 8'd255;
    end else begin
      b = q[18:11];
    end
    return b;
  endfunction

  assign tok_pix     = tok.valid && (tok.kind == TOK_PIXEL);
  assign launch      = tok.valid && pend_valid;
  assign launch_last = (tok.kind == TOK_FINISH);
  assign pop_ok      = pop && !empty;
  assign empty       = (cnt == '0);
  assign result      = q_mem[rd_ptr];

  assign occ = OCC_W'(cnt) + OCC_W'(tok_pix) + OCC_W'(pend_valid) + OCC_W'(s1_valid) +
               OCC_W'(s2_valid) + OCC_W'(s3_valid);
  assign room = (occ < OCC_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
    end else begin
      if (tok.valid) begin
        pend_valid <= tok_pix;
      end
      s1_valid <= launch;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pix) begin
      pend     <= sums;
      pend_col <= tok.col;
    end
    s1_last <= launch_last;
    s1_col  <= pend_col;
    s1_y    <= ACC_W'($signed({pend.luma, 13'd0}));
    s1_rv   <= pend.v * K_R_V;
    s1_gu   <= pend.u * K_G_U;
    s1_gv   <= pend.v * K_G_V;
    s1_bu   <= pend.u * K_B_U;
    s2_last <= s1_last;
    s2_col  <= s1_col;
    s2_r    <= s1_y + s1_rv;
    s2_g    <= s1_y - s1_gu - s1_gv;
    s2_b    <= s1_y + s1_bu;
    s3_last <= s2_last;
    s3_col  <= s2_col;
    s3_r    <= classify(s2_r);
    s3_g    <= classify(s2_g);
    s3_b    <= classify(s2_b);
  end

  always_comb begin
    conv.red         = to_byte(s3_r);
    conv.green       = to_byte(s3_g);
    conv.blue        = to_byte(s3_b);
    conv.column      = s3_col;
    conv.last_in_run = s3_last;
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      q_mem[wr_ptr] <= conv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (s3_valid) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      unique case ({s3_valid, pop_ok})
        2'b10:   cnt <= cnt + OUT_CNT_W'(1);
        2'b01:   cnt <= cnt - OUT_CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/ntsc_composite_pixel_decoder_top.sv =====
// Each pixel takes samples_per_pixel sample steps and a finish step, which loads the next
// job if one waits, plus a step per emitted RGB pixel or dropped excess-carry step, and stalls while results back up.
// A result is launched by the token that follows it (next result of the run or end of
// run) and passes registers s1, s2 and s3 before it is written to the output queue.
// Reset (rst, synchronous): registers to reset values; window, sums, phase,
// carry, column and both queues cleared. Depends on ncpd_pkg and submodules.
module ntsc_composite_pixel_decoder_top import ncpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         item,
  output logic             empty,
  input  logic             pop,
  output out_item_t        result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [OW_W-1:0]  cfg_data
);

  cfg_t  cfg;
  job_t  job;
  logic  job_valid;
  logic  job_take;
  logic  room;
  tok_t  tok;
  sums_t sums;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_phase       <= 4'd0;
      cfg.samples_per_pixel <= SPP_W'(8);
      cfg.saturation_on     <= 1'b1;
      cfg.out_width         <= OW_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_PHASE: cfg.start_phase       <= cfg_data[3:0];
        REG_SPP:         cfg.samples_per_pixel <= cfg_data[SPP_W-1:0];
        REG_SATURATION:  cfg.saturation_on     <= cfg_data[0];
        REG_OUT_WIDTH:   cfg.out_width         <= cfg_data;
      endcase
    end
  end

  ncpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .start_phase (cfg.start_phase),
    .job         (job),
    .job_valid   (job_valid),
    .job_take    (job_take)
  );

  ncpd_sampler u_sampler (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .room      (room),
    .tok       (tok),
    .sums      (sums)
  );

  ncpd_rgb u_rgb (
    .clk    (clk),
    .rst    (rst),
    .tok    (tok),
    .sums   (sums),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== sim/ntsc_composite_pixel_decoder_top_tb.sv =====
// Self-checking testbench for ntsc_composite_pixel_decoder_top: random and directed
// palette pixels go in, and each RGB beat is checked against a built-in pixel predictor.
// Depends on ncpd_pkg and the RTL under rtl/.
module ntsc_composite_pixel_decoder_top_tb import ncpd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 600;

  localparam int LEVEL_Q13 [16] = '{
    -873, 0, 2495, 5905, 3160, 5489, 8192, 8192,
    -1248, -582, 1414, 4158, 1954, 3784, 6071, 6071
  };
  localparam int SIN_Q13 [12] = '{
    15826, 15826, 11585, 4240, -4240, -11585,
    -15826, -15826, -11585, -4240, 4240, 11585
  };
  localparam int COS_Q13 [12] = '{
    4240, -4240, -11585, -15826, -15826, -11585,
    -4240, 4240, 11585, 15826, 15826, 11585
  };

  logic            clk;
  logic            rst;
  logic            push = 1'b0;
  logic            full;
  in_item_t        item = '0;
  logic            empty;
  logic            pop = 1'b0;
  out_item_t       result;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [OW_W-1:0] cfg_data;

  ntsc_composite_pixel_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state and register copies
  logic signed [15:0] window [12];
  logic [19:0]        luma_sum;
  logic [23:0]        u_sum;
  logic [23:0]        v_sum;
  logic [3:0]         color_phase;
  logic [12:0]        carry;
  logic [11:0]        col_count;
  logic [3:0]         cfg_start;
  logic [4:0]         cfg_spp;
  logic               cfg_sat;
  logic [11:0]        cfg_ow;

  in_item_t  pixels_to_send [$];
  out_item_t pixels_due [$];
  int        pixels_queued = 0;
  int        pixels_taken = 0;
  int        fail_count = 0;
  logic      in_beat = 1'b0;
  logic      out_beat = 1'b0;
  bit        steady = 1'b0;
  bit        rx_hold_req = 1'b0;
  int        rx_hold_left = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  function automatic void clear_line();
    for (int i = 0; i < 12; i++) window[i] = '0;
    luma_sum = '0;
    u_sum = '0;
    v_sum = '0;
    carry = '0;
    col_count = '0;
  endfunction

  function automatic bit in_half(int c, int p);
    return ((c + p) % 12) < 6;
  endfunction

  function automatic longint q13_round(longint v);
    longint x;
    x = v + 4096;
    if (x >= 0) return x >>> 13;
    return -((-x + 8191) >>> 13);
  endfunction

  function automatic logic [7:0] clamp_byte(longint acc);
    longint q;
    if (acc <= 0) return 8'd0;
    q = acc * 255 / (longint'(12) << 26);
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  function automatic void decode_pixel(in_item_t it);
    int         hue, level, spp, ow, thr, base, lo, hi, s, old, produced, p;
    logic [2:0] emph;
    bit         att;
    longint     du, dv, y, u, v;
    out_item_t  run [8];
    hue = it.pixel_index[3:0];
    level = it.pixel_index[5:4];
    emph = it.pixel_index[8:6];
    spp = cfg_spp;
    ow = cfg_ow;
    produced = 0;
    if (it.frame_start) begin
      clear_line();
      color_phase = 4'(cfg_start % 12);
    end else if (it.line_start) begin
      clear_line();
    end
    if (spp == 0) spp = 1;
    if (spp > 16) spp = 16;
    if (ow > 2048) ow = 2048;
    thr = 256 * spp;
    if (hue > 13) level = 1;
    for (int n = 0; n < spp; n++) begin
      color_phase = (color_phase == 0 || color_phase > 11) ? 4'd11 : color_phase - 4'd1;
      p = color_phase;
      att = (hue < 14) && ((emph[0] && in_half(12, p)) || (emph[1] && in_half(4, p)) ||
                           (emph[2] && in_half(8, p)));
      base = level + (att ? 8 : 0);
      lo = LEVEL_Q13[base];
      hi = LEVEL_Q13[base + 4];
      if (hue == 0) lo = hi;
      if (hue > 12) hi = lo;
      s = in_half(hue, p) ? hi : lo;
      old = window[p];
      window[p] = 16'(s);
      luma_sum = luma_sum + 20'(s - old);
      if (cfg_sat) begin
        du = q13_round(longint'(s) * SIN_Q13[p]) - q13_round(longint'(old) * SIN_Q13[p]);
        dv = q13_round(longint'(s) * COS_Q13[p]) - q13_round(longint'(old) * COS_Q13[p]);
        u_sum = u_sum + 24'(du);
        v_sum = v_sum + 24'(dv);
      end
      carry = carry + 13'(ow);
      while (carry >= thr && produced < 8) begin
        y = longint'($signed(luma_sum)) * 8192;
        u = longint'($signed(u_sum));
        v = longint'($signed(v_sum));
        carry = carry - 13'(thr);
        run[produced].red = clamp_byte(y + v * 9338);
        run[produced].green = clamp_byte(y - u * 3233 - v * 4756);
        run[produced].blue = clamp_byte(y + u * 16647);
        run[produced].column = col_count[10:0];
        run[produced].last_in_run = 1'b0;
        col_count = col_count + 12'd1;
        produced++;
      end
      if (carry >= thr) carry = 13'(carry % thr);
    end
    if (produced > 0) run[produced - 1].last_in_run = 1'b1;
    for (int k = 0; k < produced; k++) pixels_due = {pixels_due, run[k]};
  endfunction

  task automatic flag(string what, int got, int want);
    fail_count++;
    $display("ERROR %0t ns: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_pixel(out_item_t got);
    out_item_t want;
    if (pixels_due.size() == 0) begin
      flag("beat with nothing due, column", got.column, -1);
      return;
    end
    want = pixels_due.pop_front();
    if (got.red !== want.red) flag("red", got.red, want.red);
    if (got.green !== want.green) flag("green", got.green, want.green);
    if (got.blue !== want.blue) flag("blue", got.blue, want.blue);
    if (got.column !== want.column) flag("column", got.column, want.column);
    if (got.last_in_run !== want.last_in_run)
      flag("last_in_run", got.last_in_run, want.last_in_run);
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    in_beat = !rst && push && !full;
    out_beat = !rst && pop && !empty;
    if (in_beat) begin
      decode_pixel(item);
      pixels_taken++;
    end
    if (out_beat) check_pixel(result);
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_beat) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pixels_to_send.size() > 0) begin
        item <= pixels_to_send.pop_front();
        push <= 1'b1;
        send_gap = pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else if (out_beat) begin
      recv_gap = pick_gap();
      pop <= (recv_gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      pop <= (recv_gap == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic queue_pixel(in_item_t it);
    pixels_to_send = {pixels_to_send, it};
    pixels_queued++;
  endtask

  task automatic wait_idle();
    while (pixels_taken != pixels_queued || pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [3:0] sp, logic [4:0] spp, logic sat, logic [11:0] ow);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_PHASE;
    cfg_data <= OW_W'(sp);
    @(negedge clk);
    cfg_index <= REG_SPP;
    cfg_data <= OW_W'(spp);
    @(negedge clk);
    cfg_index <= REG_SATURATION;
    cfg_data <= OW_W'(sat);
    @(negedge clk);
    cfg_index <= REG_OUT_WIDTH;
    cfg_data <= ow;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_start = sp;
    cfg_spp = spp;
    cfg_sat = sat;
    cfg_ow = ow;
  endtask

  task automatic run_phase(int n, int line_pm, int frame_pm, bit open_line);
    in_item_t it;
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      it.pixel_index = 9'($urandom_range(0, 511));
      it.line_start = ($urandom_range(0, 999) < line_pm);
      it.frame_start = ($urandom_range(0, 999) < frame_pm);
      if (i == 0 && open_line) it.line_start = 1'b1;
      queue_pixel(it);
    end
  endtask

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_START_PHASE;
    cfg_data = '0;
    clear_line();
    color_phase = '0;
    cfg_start = 4'd0;
    cfg_spp = 5'd8;
    cfg_sat = 1'b1;
    cfg_ow = 12'd256;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values, directed pixels
    @(posedge clk);
    queue_pixel(in_item_t'{9'h000, 1'b0, 1'b1});
    queue_pixel(in_item_t'{9'h030, 1'b0, 1'b0});  // hue zero: high level only
    queue_pixel(in_item_t'{9'h1C0, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h1F0, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h1FF, 1'b0, 1'b0});  // dark hues, all emphasis
    queue_pixel(in_item_t'{9'h1CE, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h17E, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h00D, 1'b0, 1'b0});  // hue 13: low level only
    queue_pixel(in_item_t'{9'h1ED, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h00C, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h011, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h022, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h033, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h041, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h082, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h104, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h1FF, 1'b1, 1'b0});
    queue_pixel(in_item_t'{9'h155, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h0AA, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h02A, 1'b1, 1'b1});
    queue_pixel(in_item_t'{9'h0B7, 1'b0, 1'b0});
    queue_pixel(in_item_t'{9'h1FB, 1'b0, 1'b0});

    // leave a carry residue, then shrink the threshold mid-line to overflow the run
    write_regs(4'd5, 5'd16, 1'b1, 12'd1500);
    run_phase(8, 0, 0, 1'b1);
    write_regs(4'd11, 5'd1, 1'b0, 12'd2048);
    run_phase(150, 0, 0, 1'b0);

    // zero width never emits
    write_regs(4'd15, 5'd0, 1'b1, 12'd0);
    run_phase(10, 100, 100, 1'b1);

    write_regs(4'd15, 5'd0, 1'b1, 12'd4095);
    run_phase(20, 50, 150, 1'b0);

    write_regs(4'd0, 5'd31, 1'b1, 12'd2048);
    steady = 1'b1;
    run_phase(20, 30, 10, 1'b1);

    // receiver holds off while the sender keeps offering
    write_regs(4'd3, 5'd8, 1'b1, 12'd512);
    steady = 1'b0;
    rx_hold_req = 1'b1;
    run_phase(60, 20, 5, 1'b1);

    for (int k = 0; k < 5; k++) begin
      write_regs(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(128, 2048)));
      steady = ($urandom_range(0, 3) == 0);
      run_phase(20, 15, 5, 1'($urandom_range(0, 1)));
    end

    write_regs(4'd0, 5'd8, 1'b1, 12'd256);
    steady = 1'b0;
    run_phase(24, 8, 2, 1'b1);

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
